[rtl/tsb_pkg.sv]
// tsb_pkg: shared types, codes and helpers of the taint shadow bitmap.
// Depends on nothing; used by every module of the block but tsb_fifo, by scoped name.
package tsb_pkg;

   // Fixed widths of the item fields and the queue depth
   localparam int START_W     = 16;
   localparam int COUNT_W     = 9;
   localparam int QUEUE_DEPTH = 2;

   // Operation codes on req_operation
   localparam logic [1:0] OP_MARK   = 2'd0;
   localparam logic [1:0] OP_UNMARK = 2'd1;
   localparam logic [1:0] OP_TEST   = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   // Command class handed from the front end to the engine
   typedef enum logic [2:0] {
      KIND_SET  = 3'd0,
      KIND_CLR  = 3'd1,
      KIND_TEST = 3'd2,
      KIND_WIPE = 3'd3,
      KIND_NOP  = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [COUNT_W-1:0]   count;
   } cmd_type;

   // Bits pos .. pos+size-1 of one store word
   function automatic logic [7:0] part_mask(input logic [2:0] pos, input logic [3:0] size);
      logic [8:0]  ones;
      logic [15:0] wide;
      ones = (9'd1 << size) - 9'd1;
      wide = {7'd0, ones} << pos;
      return wide[7:0];
   endfunction

endpackage

[rtl/taint_shadow_bitmap_core.sv]
// taint_shadow_bitmap_core: byte-granular taint shadow map, top level.
// Flow: a test reads the addressed word (READ) and returns its bit (WRITE); mark/unmark
// pass READ then WRITE once per store word touched; zero-length runs are answered from
// IDLE; clear-all sweeps every store word. The engine takes a new command only in IDLE.
// Reset: synchronous; a clearing pass over all 2^(ADDR_BITS-3) store words follows, full held high.
module taint_shadow_bitmap_core #(
   parameter int ADDR_BITS = 16,
   parameter int MAX_RUN   = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [1:0]                   req_operation,
   input  logic [tsb_pkg::START_W-1:0]  req_start_address,
   input  logic [tsb_pkg::COUNT_W-1:0]  req_byte_count,
   output logic                         empty,
   input  logic                         pop,
   output logic                         rsp_tainted
);

   localparam int CMD_W = $bits(tsb_pkg::cmd_type) + ADDR_BITS;

   tsb_pkg::cmd_type       front_cmd, eng_cmd;
   logic [ADDR_BITS-1:0]   front_addr, eng_addr;
   logic [CMD_W-1:0]       q_rd_data;
   logic                   q_full, q_empty, q_pop;
   logic                   res_full, res_push, res_bit;
   logic                   init_busy;

   // front end
   tsb_front #(
      .ADDR_BITS (ADDR_BITS),
      .MAX_RUN   (MAX_RUN)
   ) u_front (
      .operation     (req_operation),
      .start_address (req_start_address),
      .byte_count    (req_byte_count),
      .cmd           (front_cmd),
      .cmd_addr      (front_addr)
   );

   assign full = q_full || init_busy;

   // command queue between front and engine
   tsb_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (tsb_pkg::QUEUE_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push && !full),
      .wr_data ({front_cmd, front_addr}),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   assign eng_cmd  = q_rd_data[CMD_W-1:ADDR_BITS];
   assign eng_addr = q_rd_data[ADDR_BITS-1:0];

   // back end with the store
   tsb_engine #(
      .ADDR_BITS (ADDR_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd_pop   (q_pop),
      .cmd       (eng_cmd),
      .cmd_addr  (eng_addr),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_bit   (res_bit),
      .init_busy (init_busy)
   );

   // result queue
   tsb_fifo #(
      .WIDTH (1),
      .DEPTH (tsb_pkg::QUEUE_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res_bit),
      .full    (res_full),
      .rd_en   (pop),
      .rd_data (rsp_tainted),
      .empty   (empty)
   );

endmodule

[rtl/tsb_fifo.sv]
// tsb_fifo: small register queue used between the stages of the block.
// Depends on nothing.
module tsb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_wr, do_rd;

   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // payload slots, no reset
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/tsb_front.sv]
// tsb_front: classifies an incoming beat into an engine command.
// Depends on tsb_pkg (cmd_type, kind codes, field widths).
module tsb_front #(
   parameter int ADDR_BITS = 16,
   parameter int MAX_RUN   = 256
) (
   input  logic [1:0]                    operation,
   input  logic [tsb_pkg::START_W-1:0]   start_address,
   input  logic [tsb_pkg::COUNT_W-1:0]   byte_count,
   output tsb_pkg::cmd_type              cmd,
   output logic [ADDR_BITS-1:0]          cmd_addr
);

   logic [31:0]                  count_wide;
   logic [tsb_pkg::COUNT_W-1:0]  count_sat;
   logic                         run_empty;

   // address taken modulo the tracked space
   generate
      if (ADDR_BITS <= tsb_pkg::START_W) begin : g_addr_trim
         assign cmd_addr = start_address[ADDR_BITS-1:0];
      end else begin : g_addr_ext
         assign cmd_addr = {{(ADDR_BITS - tsb_pkg::START_W){1'b0}}, start_address};
      end
   endgenerate

   // long runs saturate to the run limit
   assign count_wide = 32'(byte_count);
   assign count_sat  = (count_wide > 32'(MAX_RUN)) ? tsb_pkg::COUNT_W'(MAX_RUN) : byte_count;
   assign run_empty  = (byte_count == '0);

   // classify the operation
   always_comb begin
      cmd.count = count_sat;
      unique case (operation)
         tsb_pkg::OP_MARK:   cmd.kind = run_empty ? tsb_pkg::KIND_NOP : tsb_pkg::KIND_SET;
         tsb_pkg::OP_UNMARK: cmd.kind = run_empty ? tsb_pkg::KIND_NOP : tsb_pkg::KIND_CLR;
         tsb_pkg::OP_TEST:   cmd.kind = tsb_pkg::KIND_TEST;
         tsb_pkg::OP_CLEAR:  cmd.kind = tsb_pkg::KIND_WIPE;
         default:            cmd.kind = tsb_pkg::KIND_NOP;
      endcase
   end

endmodule

[rtl/tsb_engine.sv]
// tsb_engine: back end; owns the taint store and runs read-modify-write,
// byte tests and clearing sweeps. Depends on tsb_pkg.
module tsb_engine #(
   parameter int ADDR_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_pop,
   input  tsb_pkg::cmd_type      cmd,
   input  logic [ADDR_BITS-1:0]  cmd_addr,
   input  logic                  res_full,
   output logic                  res_push,
   output logic                  res_bit,
   output logic                  init_busy
);

   localparam int WORD_W = ADDR_BITS - 3;
   localparam int WORDS  = 2 ** WORD_W;
   localparam int CW     = tsb_pkg::COUNT_W;

   typedef enum logic [3:0] {
      ST_SWEEP = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_WRITE = 4'b1000
   } eng_state_type;

   eng_state_type          state_ff, state_in;
   logic [ADDR_BITS-1:0]   addr_ff, addr_in;
   logic [CW-1:0]          count_ff, count_in;
   tsb_pkg::kind_type      kind_ff, kind_in;
   logic                   wipe_ff, wipe_in;
   logic [WORD_W-1:0]      sweep_ff, sweep_in;
   logic [7:0]             rd_data_ff;
   logic [7:0]             store [WORDS];

   logic [2:0]             pos;
   logic [3:0]             room;
   logic [3:0]             size;
   logic [7:0]             mask;
   logic                   last_word;
   logic                   mem_we;
   logic [WORD_W-1:0]      mem_wa;
   logic [7:0]             mem_wd;

   // split of the run at the current word
   assign pos       = addr_ff[2:0];
   assign room      = 4'd8 - {1'b0, pos};
   assign size      = (count_ff < CW'(room)) ? count_ff[3:0] : room;
   assign mask      = tsb_pkg::part_mask(pos, size);
   assign last_word = (count_ff == CW'(size));
   assign init_busy = (state_ff == ST_SWEEP) && !wipe_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      count_in = count_ff;
      kind_in  = kind_ff;
      wipe_in  = wipe_ff;
      sweep_in = sweep_ff;
      cmd_pop  = 1'b0;
      res_push = 1'b0;
      res_bit  = 1'b0;
      mem_we   = 1'b0;
      mem_wa   = addr_ff[ADDR_BITS-1:3];
      mem_wd   = (kind_ff == tsb_pkg::KIND_SET) ? (rd_data_ff | mask) : (rd_data_ff & ~mask);
      unique case (state_ff)
         ST_SWEEP: begin
            mem_we   = 1'b1;
            mem_wa   = sweep_ff;
            mem_wd   = '0;
            sweep_in = sweep_ff + WORD_W'(1);
            if (sweep_ff == WORD_W'(WORDS - 1)) begin
               state_in = ST_IDLE;
               res_push = wipe_ff;
               wipe_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            // take a command only when its result is sure to fit
            if (cmd_valid && !res_full) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  tsb_pkg::KIND_WIPE: begin
                     wipe_in  = 1'b1;
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end
                  tsb_pkg::KIND_NOP: begin
                     res_push = 1'b1;
                  end
                  default: begin
                     addr_in  = cmd_addr;
                     count_in = cmd.count;
                     kind_in  = cmd.kind;
                     state_in = ST_READ;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (kind_ff == tsb_pkg::KIND_TEST) begin
               res_push = 1'b1;
               res_bit  = rd_data_ff[pos];
               state_in = ST_IDLE;
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff - CW'(size);
               addr_in  = addr_ff + ADDR_BITS'(size);
               if (last_word) begin
                  res_push = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         wipe_ff  <= 1'b0;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         wipe_ff  <= wipe_in;
         sweep_ff <= sweep_in;
      end
   end

   // working registers of the current command
   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      count_ff <= count_in;
      kind_ff  <= kind_in;
   end

   // taint store: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_wa] <= mem_wd;
      end
      rd_data_ff <= store[addr_ff[ADDR_BITS-1:3]];
   end

endmodule

[rtl/tsb_checker.sv]
// tsb_checker: port-level checks of the taint shadow bitmap, bound to the top.
// Depends on tsb_pkg (queue depth).
module tsb_checker (
   input logic clock,
   input logic reset,
   input logic push,
   input logic full,
   input logic empty,
   input logic pop,
   input logic rsp_tainted
);

   // command queue, engine and result queue together
   localparam logic [3:0] MAX_OUT = 4'(2 * tsb_pkg::QUEUE_DEPTH + 1);

   logic [3:0] outstanding_ff, outstanding_in;
   logic       in_beat, out_beat;

   assign in_beat  = push && !full;
   assign out_beat = pop && !empty;

   // items accepted but not yet delivered
   always_comb begin
      outstanding_in = outstanding_ff;
      if (in_beat && !out_beat) begin
         outstanding_in = outstanding_ff + 4'd1;
      end else if (out_beat && !in_beat) begin
         outstanding_in = outstanding_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // clearing pass keeps the input closed right after reset
   a_reset_sweep: assert property (@(posedge clock) reset |=> full)
      else $error("input open during clearing pass");

   // a waiting result holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_tainted)))
      else $error("result changed while stalled");

   // no result without an item behind it
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (outstanding_ff != 4'd0))
      else $error("result without accepted item");

   // the pipeline never holds more than its queues and engine allow
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= MAX_OUT)
      else $error("more items in flight than capacity");

endmodule

bind taint_shadow_bitmap_core tsb_checker u_tsb_checker (
   .clock       (clock),
   .reset       (reset),
   .push        (push),
   .full        (full),
   .empty       (empty),
   .pop         (pop),
   .rsp_tainted (rsp_tainted)
);
